// ----- rtl/core/ifp_pkg.sv -----
package ifp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // Special expression bytes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOOPEN = 2'd2;

  // Microprogram addresses
  localparam int PCW = 5;
  localparam logic [PCW-1:0] PC_FETCH    = 5'd0;
  localparam logic [PCW-1:0] PC_OPND     = 5'd1;
  localparam logic [PCW-1:0] PC_OPEN     = 5'd2;
  localparam logic [PCW-1:0] PC_CL_TEST  = 5'd3;
  localparam logic [PCW-1:0] PC_CL_TOP   = 5'd4;
  localparam logic [PCW-1:0] PC_CL_POP   = 5'd5;
  localparam logic [PCW-1:0] PC_CL_FILL  = 5'd6;
  localparam logic [PCW-1:0] PC_CL_DROP  = 5'd7;
  localparam logic [PCW-1:0] PC_CL_DFILL = 5'd8;
  localparam logic [PCW-1:0] PC_OP_TEST  = 5'd9;
  localparam logic [PCW-1:0] PC_OP_POP   = 5'd10;
  localparam logic [PCW-1:0] PC_OP_FILL  = 5'd11;
  localparam logic [PCW-1:0] PC_OP_PUSH  = 5'd12;
  localparam logic [PCW-1:0] PC_FL_CHK   = 5'd13;
  localparam logic [PCW-1:0] PC_FL_TEST  = 5'd14;
  localparam logic [PCW-1:0] PC_FL_POP   = 5'd15;
  localparam logic [PCW-1:0] PC_FL_FILL  = 5'd16;
  localparam logic [PCW-1:0] PC_FINISH   = 5'd17;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,    // take input transaction, latch byte and status
    ACT_EMIT_CH,   // emit latched byte
    ACT_POP_EMIT,  // emit top, pop
    ACT_POP,       // pop without emit
    ACT_FILL,      // reload top from stack memory
    ACT_PUSH,      // push latched byte, dropped when full
    ACT_FINISH     // release held result with end flags, or a marker
  } act_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_DISPATCH,  // jump by class of input byte
    CND_CNT_ZERO,
    CND_TOP_OPEN,
    CND_NO_POP,    // empty or top binds weaker than current operator
    CND_NOT_LAST
  } cond_t;

  typedef struct packed {
    act_t           act;
    cond_t          cond;
    logic [PCW-1:0] tgt;
  } ctrl_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_MUL || c == CH_DIV)    p = 2'd2;
    return p;
  endfunction

  function automatic logic [PCW-1:0] dispatch_tgt(input logic [7:0] c);
    logic [PCW-1:0] t;
    t = PC_OPND;
    if (c == CH_LPAR)           t = PC_OPEN;
    else if (c == CH_RPAR)      t = PC_CL_TEST;
    else if (prec_of(c) != 2'd0) t = PC_OP_TEST;
    return t;
  endfunction

  // Control store
  function automatic ctrl_t ucode(input logic [PCW-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      PC_FETCH:    cw = '{ACT_ACCEPT,   CND_DISPATCH, PC_FETCH};
      PC_OPND:     cw = '{ACT_EMIT_CH,  CND_ALWAYS,   PC_FL_CHK};
      PC_OPEN:     cw = '{ACT_PUSH,     CND_ALWAYS,   PC_FL_CHK};
      PC_CL_TEST:  cw = '{ACT_NONE,     CND_CNT_ZERO, PC_FL_CHK};
      PC_CL_TOP:   cw = '{ACT_NONE,     CND_TOP_OPEN, PC_CL_DROP};
      PC_CL_POP:   cw = '{ACT_POP_EMIT, CND_NEVER,    PC_FETCH};
      PC_CL_FILL:  cw = '{ACT_FILL,     CND_ALWAYS,   PC_CL_TEST};
      PC_CL_DROP:  cw = '{ACT_POP,      CND_NEVER,    PC_FETCH};
      PC_CL_DFILL: cw = '{ACT_FILL,     CND_ALWAYS,   PC_FL_CHK};
      PC_OP_TEST:  cw = '{ACT_NONE,     CND_NO_POP,   PC_OP_PUSH};
      PC_OP_POP:   cw = '{ACT_POP_EMIT, CND_NEVER,    PC_FETCH};
      PC_OP_FILL:  cw = '{ACT_FILL,     CND_ALWAYS,   PC_OP_TEST};
      PC_OP_PUSH:  cw = '{ACT_PUSH,     CND_NEVER,    PC_FETCH};
      PC_FL_CHK:   cw = '{ACT_NONE,     CND_NOT_LAST, PC_FINISH};
      PC_FL_TEST:  cw = '{ACT_NONE,     CND_CNT_ZERO, PC_FINISH};
      PC_FL_POP:   cw = '{ACT_POP_EMIT, CND_NEVER,    PC_FETCH};
      PC_FL_FILL:  cw = '{ACT_FILL,     CND_ALWAYS,   PC_FL_TEST};
      PC_FINISH:   cw = '{ACT_FINISH,   CND_ALWAYS,   PC_FETCH};
      default:     cw = '{ACT_NONE,     CND_ALWAYS,   PC_FETCH};
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/core/infix_to_postfix_converter.sv -----
// Shunting-yard infix to postfix converter. Each input transaction carries one
// expression byte (tlast marks the final byte); + - * / ( ) are operators and
// every other byte is an operand that passes straight through. Each output
// transaction carries one postfix byte, or a marker with has_char low when a
// byte produced nothing but has an error status or ends the expression; tlast
// flags the last output caused by an input byte. A small microprogram in a
// read-only control store sequences a plain datapath: a top-of-stack register
// backed by a stack memory with one write port and one registered read port
// that holds the entries below the top. For an operator byte, each stacked
// operator popped takes a test, a pop and a refill of the top from memory;
// for a close parenthesis each one popped takes a test, a top check, a pop
// and a refill, and the discard of its open parenthesis takes a drop and a
// refill; the final byte flushes each entry with a test, a pop and a refill.
// Output back-pressure stalls the sequencer once one result is waiting in the
// output register and one is held internally. No clearing pass after reset:
// the stack memory is only read below the fill count. A push onto a full
// stack is dropped (status 1); a close parenthesis without an open one gives
// status 2. Status is the same on every output of one input byte.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // expr_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // run_last
  output logic [3:0] out_tuser   // [0] has_char, [1] expr_end, [3:2] status
);
  import ifp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);  // fill count
  localparam int AW = $clog2(STACK_DEPTH);      // memory address
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  // Sequencer
  logic [PCW-1:0] pc_r, pc_nxt;
  ctrl_t          cw;
  logic           stall, jump;

  // Datapath
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] open_r, open_nxt;   // '(' entries on the stack
  logic [7:0]    top_r, top_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    prec_r, prec_nxt;
  logic [1:0]    status_r, status_nxt;

  // Held result, released once we know whether it is the last of the byte
  logic          pend_vld_r, pend_vld_nxt;
  logic [7:0]    pend_char_r, pend_char_nxt;

  // Output register
  logic          out_vld_r, out_vld_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_has_r, out_has_nxt;
  logic          out_rl_r, out_rl_nxt;
  logic          out_end_r, out_end_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  // Stack memory, entries below the top register
  logic [7:0]    mem [STACK_DEPTH];
  logic [7:0]    rd_q_r;
  logic          mem_we;
  logic [CW-1:0] cnt_m1, cnt_m2;

  logic          out_busy, emit_act;
  logic [7:0]    emit_char;
  logic [1:0]    in_prec;

  assign cw       = ucode(pc_r);
  assign out_busy = out_vld_r && !out_tready;
  assign emit_act = (cw.act == ACT_EMIT_CH) || (cw.act == ACT_POP_EMIT);
  assign emit_char = (cw.act == ACT_EMIT_CH) ? ch_r : top_r;
  assign in_prec  = prec_of(in_tdata);
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);

  assign in_tready = rst_n && (cw.act == ACT_ACCEPT);

  always_comb begin
    stall = 1'b0;
    if (cw.act == ACT_ACCEPT && !in_tvalid)         stall = 1'b1;
    if (emit_act && pend_vld_r && out_busy)         stall = 1'b1;
    if (cw.act == ACT_FINISH && out_busy)           stall = 1'b1;
  end

  always_comb begin
    unique case (cw.cond)
      CND_NEVER:    jump = 1'b0;
      CND_ALWAYS:   jump = 1'b1;
      CND_DISPATCH: jump = 1'b1;
      CND_CNT_ZERO: jump = (cnt_r == '0);
      CND_TOP_OPEN: jump = (top_r == CH_LPAR);
      CND_NO_POP:   jump = (cnt_r == '0) || (prec_of(top_r) < prec_r);
      CND_NOT_LAST: jump = !last_r;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stall)                     pc_nxt = pc_r;
    else if (!jump)                pc_nxt = pc_r + PCW'(1);
    else if (cw.cond == CND_DISPATCH) pc_nxt = dispatch_tgt(in_tdata);
    else                           pc_nxt = cw.tgt;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    open_nxt      = open_r;
    top_nxt       = top_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    prec_nxt      = prec_r;
    status_nxt    = status_r;
    pend_vld_nxt  = pend_vld_r;
    pend_char_nxt = pend_char_r;
    mem_we        = 1'b0;

    out_vld_nxt  = out_vld_r && !out_tready;
    out_char_nxt = out_char_r;
    out_has_nxt  = out_has_r;
    out_rl_nxt   = out_rl_r;
    out_end_nxt  = out_end_r;
    out_st_nxt   = out_st_r;

    if (!stall) begin
      case (cw.act)
        ACT_ACCEPT: begin
          ch_nxt     = in_tdata;
          last_nxt   = in_tlast;
          prec_nxt   = in_prec;
          status_nxt = ST_OK;
          if (in_tdata == CH_LPAR) begin
            if (cnt_r == FULL_CNT) status_nxt = ST_FULL;
          end else if (in_tdata == CH_RPAR) begin
            if (open_r == '0) status_nxt = ST_NOOPEN;
          end else if (in_prec != 2'd0) begin
            // full only when nothing gets popped ahead of the push
            if (cnt_r == FULL_CNT && prec_of(top_r) < in_prec) status_nxt = ST_FULL;
          end
        end
        ACT_EMIT_CH, ACT_POP_EMIT: begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_char_nxt = pend_char_r;
            out_has_nxt  = 1'b1;
            out_rl_nxt   = 1'b0;
            out_end_nxt  = 1'b0;
            out_st_nxt   = status_r;
          end
          pend_vld_nxt  = 1'b1;
          pend_char_nxt = emit_char;
          if (cw.act == ACT_POP_EMIT) begin
            cnt_nxt = cnt_m1;
            if (top_r == CH_LPAR) open_nxt = open_r - CW'(1);
          end
        end
        ACT_POP: begin
          cnt_nxt = cnt_m1;
          if (top_r == CH_LPAR) open_nxt = open_r - CW'(1);
        end
        ACT_FILL: begin
          top_nxt = rd_q_r;
        end
        ACT_PUSH: begin
          if (cnt_r != FULL_CNT) begin
            mem_we  = (cnt_r != '0);
            cnt_nxt = cnt_r + CW'(1);
            top_nxt = ch_r;
            if (ch_r == CH_LPAR) open_nxt = open_r + CW'(1);
          end
        end
        ACT_FINISH: begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_char_nxt = pend_char_r;
            out_has_nxt  = 1'b1;
            out_rl_nxt   = 1'b1;
            out_end_nxt  = last_r;
            out_st_nxt   = status_r;
            pend_vld_nxt = 1'b0;
          end else if (status_r != ST_OK || last_r) begin
            out_vld_nxt  = 1'b1;
            out_char_nxt = 8'h00;
            out_has_nxt  = 1'b0;
            out_rl_nxt   = 1'b1;
            out_end_nxt  = last_r;
            out_st_nxt   = status_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stack memory: spill old top on push, read the entry under the new top on
  // every cycle so a pop can refill the top register in the next cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[AW-1:0]] <= top_r;
    end
    rd_q_r <= mem[cnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= PC_FETCH;
      cnt_r      <= '0;
      open_r     <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pc_r       <= pc_nxt;
      cnt_r      <= cnt_nxt;
      open_r     <= open_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    top_r       <= top_nxt;
    ch_r        <= ch_nxt;
    last_r      <= last_nxt;
    prec_r      <= prec_nxt;
    status_r    <= status_nxt;
    pend_char_r <= pend_char_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_rl_r    <= out_rl_nxt;
    out_end_r   <= out_end_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_rl_r;
  assign out_tuser  = {out_st_r, out_end_r, out_has_r};

endmodule

// ----- rtl/core/ifp_checker.sv -----
module ifp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [3:0] out_tuser
);
  import ifp_pkg::*;

  // expression end only on the last transaction of a byte
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("expr_end without run_last");

  // marker carries no byte and closes its run
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'h00 && out_tlast)
    else $error("bad marker transaction");

  // a marker exists only for an error or an expression end
  a_marker_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] || out_tuser[3:2] != ST_OK)
    else $error("marker without cause");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[3:2] == ST_OK || out_tuser[3:2] == ST_FULL ||
                   out_tuser[3:2] == ST_NOOPEN)
    else $error("undefined status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind infix_to_postfix_converter ifp_checker u_ifp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/infix_to_postfix_converter_tb.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import ifp_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int RANDOM_BYTES = 225;
  // Longest quiet stretch: sender gap + a full pop burst + receiver stall,
  // with a wide margin.
  localparam int IDLE_LIMIT   = 3000;
  // Cycles after the last expected transaction to catch stray outputs.
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 21;

  // One postfix output transaction, fields in the order of the result.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       run_last;
    logic       expr_end;
    logic [1:0] status;
  } postfix_t;

  // One expression byte to send. When 'fixed' is set the single expected
  // result is given in 'want' instead of coming from the predictor.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fixed;
    postfix_t   want;
  } expr_byte_t;

  typedef enum int {SEQ_EXPR, SEQ_DEEP, SEQ_NOISE} seq_kind_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_char
  logic       in_tlast   = 1'b0;   // expr_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_char
  logic       out_tlast;           // run_last
  logic [3:0] out_tuser;           // [0] has_char, [1] expr_end, [3:2] status

  always #4 clk = ~clk;

  infix_to_postfix_converter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  expr_byte_t expr_bytes[$];   // everything the sender will send, in order
  postfix_t   step_out[$];     // predictor output for the byte just accepted
  postfix_t   postfix_due[$];  // outputs still owed by the block, oldest first
  int         errors = 0;

  // Predictor copy of the operator stack.
  logic [7:0] op_stack_m [DEPTH];
  int         op_depth = 0;

  // Directed part. Rows with fixed=1 carry their single expected output;
  // the others are checked against the predictor.
  expr_byte_t directed_tbl [0:N_DIRECTED-1] = '{
    // close paren on an empty stack: marker only, status no-open
    '{CH_RPAR, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ST_NOOPEN}},
    // operand extremes pass straight through
    '{8'h00,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, ST_OK}},
    '{8'hFF,   1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, ST_OK}},
    // "()" as a whole expression: nothing emitted, end marker only
    '{CH_LPAR, 1'b0, 1'b0, '0},
    '{CH_RPAR, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OK}},
    // a+b*c-d/e: mixed precedence, pops on equal and higher binding
    '{"a",      1'b0, 1'b0, '0},
    '{CH_PLUS,  1'b0, 1'b0, '0},
    '{"b",      1'b0, 1'b0, '0},
    '{CH_MUL,   1'b0, 1'b0, '0},
    '{"c",      1'b0, 1'b0, '0},
    '{CH_MINUS, 1'b0, 1'b0, '0},
    '{"d",      1'b0, 1'b0, '0},
    '{CH_DIV,   1'b0, 1'b0, '0},
    '{"e",      1'b1, 1'b0, '0},
    // x-y) : close without open after popping the stacked operator
    '{"x",      1'b0, 1'b0, '0},
    '{CH_MINUS, 1'b0, 1'b0, '0},
    '{"y",      1'b0, 1'b0, '0},
    '{CH_RPAR,  1'b0, 1'b0, '0},
    // unmatched open paren flushed at the end is emitted as '('
    '{CH_LPAR,  1'b0, 1'b0, '0},
    '{CH_MUL,   1'b1, 1'b0, '0},
    // lone operator as a whole expression
    '{CH_PLUS,  1'b1, 1'b1, '{CH_PLUS, 1'b1, 1'b1, 1'b1, ST_OK}}
  };

  // ---------------------------------------------------------------------------
  // Shunting-yard predictor
  // ---------------------------------------------------------------------------
  function automatic int op_rank(input logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    if (c == CH_MUL || c == CH_DIV) return 2;
    return 0;
  endfunction

  // Advances the predictor by one byte and leaves its outputs in step_out.
  function automatic void shunt_step(input logic [7:0] c, input logic last);
    logic [7:0] emitted[$];
    logic [1:0] st;
    postfix_t   r;
    st = ST_OK;
    step_out.delete();
    if (c == CH_LPAR) begin
      if (op_depth < DEPTH) begin
        op_stack_m[op_depth] = c;
        op_depth++;
      end else begin
        st = ST_FULL;
      end
    end else if (c == CH_RPAR) begin
      while (op_depth > 0 && op_stack_m[op_depth-1] != CH_LPAR) begin
        op_depth--;
        emitted = {emitted, op_stack_m[op_depth]};
      end
      if (op_depth > 0) op_depth--;
      else st = ST_NOOPEN;
    end else if (op_rank(c) != 0) begin
      // '(' ranks 0, so popping stops at an open paren
      while (op_depth > 0 && op_rank(c) <= op_rank(op_stack_m[op_depth-1])) begin
        op_depth--;
        emitted = {emitted, op_stack_m[op_depth]};
      end
      if (op_depth < DEPTH) begin
        op_stack_m[op_depth] = c;
        op_depth++;
      end else begin
        st = ST_FULL;
      end
    end else begin
      emitted = {emitted, c};
    end

    if (last) begin
      while (op_depth > 0) begin
        op_depth--;
        emitted = {emitted, op_stack_m[op_depth]};
      end
    end

    if (emitted.size() == 0) begin
      // silent byte, or a marker for an error or the end of the expression
      if (st == ST_OK && !last) return;
      r = '{8'h00, 1'b0, 1'b1, last, st};
      step_out = {step_out, r};
      return;
    end
    foreach (emitted[k]) begin
      r.ch       = emitted[k];
      r.has_ch   = 1'b1;
      r.run_last = (k == emitted.size() - 1);
      r.expr_end = r.run_last && last;
      r.status   = st;
      step_out = {step_out, r};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] c);
    expr_byte_t t;
    t    = '0;
    t.ch = c;
    expr_bytes = {expr_bytes, t};
  endfunction

  function automatic logic [7:0] any_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (op_rank(c) != 0 || c == CH_LPAR || c == CH_RPAR);
    return c;
  endfunction

  function automatic logic [7:0] any_operator();
    logic [7:0] ops [4];
    ops = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV};
    return ops[$urandom_range(0, 3)];
  endfunction

  // Well-formed expression with random nesting; now and then the closing
  // parens are left off so the final flush sees open parens.
  function automatic void gen_expression();
    int n_opnd;
    int depth;
    depth  = 0;
    n_opnd = $urandom_range(1, 10);
    for (int k = 0; k < n_opnd; k++) begin
      while (depth < 8 && $urandom_range(0, 3) == 0) begin
        add_byte(CH_LPAR);
        depth++;
      end
      add_byte(any_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_byte(CH_RPAR);
        depth--;
      end
      if (k != n_opnd - 1) add_byte(any_operator());
    end
    if ($urandom_range(0, 9) != 0) begin
      while (depth > 0) begin
        add_byte(CH_RPAR);
        depth--;
      end
    end
    expr_bytes[expr_bytes.size()-1].last = 1'b1;
  endfunction

  // Nest deep enough to fill the stack, then push into it and flush long runs.
  function automatic void gen_deep_nest();
    int n;
    n = $urandom_range(DEPTH - 2, DEPTH + 3);
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 4) == 0) add_byte(any_operator());
      else add_byte(CH_LPAR);
    end
    add_byte(any_operand());
    add_byte(any_operator());
    add_byte(CH_LPAR);
    repeat ($urandom_range(0, 3)) add_byte(CH_RPAR);
    add_byte(any_operand());
    expr_bytes[expr_bytes.size()-1].last = 1'b1;
  endfunction

  // Arbitrary bytes, heavy on the special ones, with random end marks.
  function automatic void gen_noise();
    logic [7:0] specials [6];
    expr_byte_t t;
    specials = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_LPAR, CH_RPAR};
    repeat ($urandom_range(1, 8)) begin
      t = '0;
      if ($urandom_range(0, 1) == 0) t.ch = specials[$urandom_range(0, 5)];
      else t.ch = 8'($urandom_range(0, 255));
      t.last = ($urandom_range(0, 4) == 0);
      expr_bytes = {expr_bytes, t};
    end
  endfunction

  // Idle length for either side: mostly none or short, a few long, and
  // calm stretches with no idling at all.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: walks the byte list, predicts on every accepted input transaction
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    int unsigned calm;
    int          seq_idx;
    seq_kind_t   kind;
    expr_byte_t  t;
    calm    = 0;
    seq_idx = 0;

    foreach (directed_tbl[i]) expr_bytes = {expr_bytes, directed_tbl[i]};
    while (expr_bytes.size() < N_DIRECTED + RANDOM_BYTES) begin
      // a deep nest now and then, the rest mostly well-formed expressions
      if (seq_idx % 10 == 3) kind = SEQ_DEEP;
      else if ($urandom_range(0, 99) < 75) kind = SEQ_EXPR;
      else kind = SEQ_NOISE;
      case (kind)
        SEQ_EXPR: gen_expression();
        SEQ_DEEP: gen_deep_nest();
        default:  gen_noise();
      endcase
      seq_idx++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (expr_bytes[i]) begin
      t   = expr_bytes[i];
      gap = idle_len(calm);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= t.ch;
      in_tlast  <= t.last;
      do @(posedge clk); while (!in_tready);
      shunt_step(t.ch, t.last);
      if (t.fixed) postfix_due = {postfix_due, t.want};
      else foreach (step_out[k]) postfix_due = {postfix_due, step_out[k]};
    end
    in_tvalid <= 1'b0;

    while (postfix_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure on the output channel
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    int unsigned calm;
    calm = 0;
    forever begin
      stall = idle_len(calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  postfix_t seen;
  postfix_t want;

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      seen = '{out_tdata, out_tuser[0], out_tlast, out_tuser[1], out_tuser[3:2]};
      if (postfix_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output char=%h has=%b run_last=%b end=%b st=%0d",
                 $time, seen.ch, seen.has_ch, seen.run_last, seen.expr_end, seen.status);
      end else begin
        want = postfix_due.pop_front();
        if (seen.ch !== want.ch || seen.has_ch !== want.has_ch ||
            seen.run_last !== want.run_last || seen.expr_end !== want.expr_end ||
            seen.status !== want.status) begin
          errors++;
          $display("%0t: mismatch exp char=%h has=%b run_last=%b end=%b st=%0d",
                   $time, want.ch, want.has_ch, want.run_last, want.expr_end,
                   want.status);
          $display("%0t:          got char=%h has=%b run_last=%b end=%b st=%0d",
                   $time, seen.ch, seen.has_ch, seen.run_last, seen.expr_end,
                   seen.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no transaction moves on either side for too long
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ifp_pkg.sv
rtl/core/infix_to_postfix_converter.sv
rtl/core/ifp_checker.sv
tb/sv/infix_to_postfix_converter_tb.sv
